@@ hdl/pad_pkg.sv @@
// Shared types and constants for the package archive deframer.
package pad_pkg;

    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned ROLE_W         = 3;
    localparam int unsigned INDEX_W        = 16;
    localparam int unsigned STATUS_W       = 4;
    localparam int unsigned LEN_W          = 32;

    localparam int unsigned MAX_PATH_BYTES = 128;
    localparam logic [31:0] MAGIC_WORD     = 32'h474B_504C;
    localparam logic [7:0]  FMT_VERSION    = 8'd1;
    localparam logic [31:0] HEADER_BYTES   = 32'd7;
    localparam logic [7:0]  SLASH_CHAR     = 8'h2F;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_PLEN   = 6'b000010,
        PH_PATH   = 6'b000100,
        PH_SIZE   = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_STOP   = 6'b100000
    } phase_t;

    typedef logic [ROLE_W-1:0] role_t;
    localparam role_t ROLE_HEADER  = 3'd0;
    localparam role_t ROLE_PLEN    = 3'd1;
    localparam role_t ROLE_PATH    = 3'd2;
    localparam role_t ROLE_SIZE    = 3'd3;
    localparam role_t ROLE_DATA    = 3'd4;
    localparam role_t ROLE_SKIPPED = 3'd5;
    localparam role_t ROLE_IGNORED = 3'd6;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_RUNNING    = 4'd0;
    localparam status_t ST_DONE       = 4'd1;
    localparam status_t ST_TOO_SMALL  = 4'd2;
    localparam status_t ST_BAD_MAGIC  = 4'd3;
    localparam status_t ST_BAD_VER    = 4'd4;
    localparam status_t ST_TRUNC_PLEN = 4'd5;
    localparam status_t ST_BAD_PATH   = 4'd6;
    localparam status_t ST_TRUNC_SIZE = 4'd7;
    localparam status_t ST_TRUNC_DATA = 4'd8;

endpackage

@@ hdl/pad_ifs.sv @@
// Stream interfaces for the deframer input bytes and tagged output bytes.
interface pad_in_if
    import pad_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              start_flag;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output start_flag, output data_byte, input ready);
    modport sink   (input valid, input start_flag, input data_byte, output ready);
endinterface

interface pad_out_if
    import pad_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   byte_out;
    role_t               byte_role;
    logic [INDEX_W-1:0]  file_index;
    logic                path_absolute;
    logic                file_end;
    status_t             parse_status;

    modport source (output valid, output byte_out, output byte_role, output file_index,
                    output path_absolute, output file_end, output parse_status,
                    input ready);
    modport sink   (input valid, input byte_out, input byte_role, input file_index,
                    input path_absolute, input file_end, input parse_status,
                    output ready);
endinterface

@@ hdl/package_archive_deframer.sv @@
// Package archive deframer: parses an archive byte stream and tags every byte.
//
// Channels: item carries one archive byte (data_byte) and start_flag, which
// restarts the parser with that byte at offset 0. result carries the byte back
// with its role, file entry index, absolute-path mark, end-of-entry mark and
// the parse status. cfg_we/cfg_wdata write package_length, the total archive
// size used by every bound check; write it only while the block is idle.
// A byte taken on item goes into the input register, then through the parse logic
// into the result register.
// Throughput: one byte per cycle while result does not stall, limited by the update
// of the parser state (offset, field counter and the 34-bit bound compare).
// Once a status other than running is reached it sticks, and later bytes are
// tagged as ignored until a byte with start_flag arrives.
// Reset clears package_length and all parser state; both stages come up empty.
// When result stalls, the result register holds, the input register takes one
// more byte, and item.ready drops until result drains.
module package_archive_deframer
    import pad_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [LEN_W-1:0]    cfg_wdata,
    pad_in_if.sink              item,
    pad_out_if.source           result
);

    logic [LEN_W-1:0]   pkg_len_reg;

    logic               s1_valid_reg;
    logic               s1_start_reg;
    logic [BYTE_W-1:0]  s1_byte_reg;

    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    role_t              out_role_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic               out_abs_reg;
    logic               out_fend_reg;
    status_t            out_status_reg;

    logic [31:0]        off_reg,   off_next;
    phase_t             phase_reg, phase_next;
    logic [31:0]        rem_reg,   rem_next;
    logic [15:0]        ftot_reg,  ftot_next;
    logic [15:0]        cur_reg,   cur_next;
    logic [31:0]        asm_reg,   asm_next;
    logic               mark_reg,  mark_next;
    status_t            stat_reg,  stat_next;

    logic [31:0]        e_off;
    phase_t             e_phase;
    logic [31:0]        e_rem;
    logic [15:0]        e_ftot;
    logic [15:0]        e_cur;
    logic [31:0]        e_asm;
    logic               e_mark;
    status_t            e_stat;

    logic               s2_ready;
    logic               fire;
    logic [BYTE_W-1:0]  b;
    logic [1:0]         lane;
    logic [31:0]        asm_or;
    logic [32:0]        next_off;
    logic [33:0]        sum_two;
    logic [33:0]        sum_chk;
    logic [31:0]        chk_add;
    logic [33:0]        len_ext;
    logic [15:0]        plen;
    logic [31:0]        rem_dec;
    logic [15:0]        cur_inc;
    role_t              role;
    logic               absv;
    logic               fend;

    assign s2_ready   = !out_valid_reg || result.ready;
    assign item.ready = !s1_valid_reg || s2_ready;
    assign fire       = s1_valid_reg && s2_ready;
    assign b          = s1_byte_reg;

    // effective state: a start byte sees the cleared parser
    always_comb
    begin
        if (s1_start_reg)
        begin
            e_off   = '0;
            e_phase = PH_HEADER;
            e_rem   = '0;
            e_ftot  = '0;
            e_cur   = '0;
            e_asm   = '0;
            e_mark  = 1'b0;
            e_stat  = ST_RUNNING;
        end
        else
        begin
            e_off   = off_reg;
            e_phase = phase_reg;
            e_rem   = rem_reg;
            e_ftot  = ftot_reg;
            e_cur   = cur_reg;
            e_asm   = asm_reg;
            e_mark  = mark_reg;
            e_stat  = stat_reg;
        end
    end

    always_comb
    begin
        case (e_phase)
            PH_HEADER: lane = (e_off[2:0] == 3'd6) ? 2'd1 : e_off[1:0];
            PH_PLEN:   lane = (e_rem[1:0] == 2'd2) ? 2'd0 : 2'd1;
            PH_SIZE:   lane = 2'd0 - e_rem[1:0];
            default:   lane = 2'd0;
        endcase
    end

    assign asm_or   = e_asm | ({24'b0, b} << {lane, 3'b000});
    assign plen     = asm_or[15:0];
    assign rem_dec  = e_rem - 32'd1;
    assign cur_inc  = e_cur + 16'd1;
    assign next_off = {1'b0, e_off} + 33'd1;
    assign len_ext  = {2'b00, pkg_len_reg};
    assign sum_two  = {1'b0, next_off} + 34'd2;

    always_comb
    begin
        case (e_phase)
            PH_PLEN: chk_add = {16'b0, plen};
            PH_PATH: chk_add = 32'd4;
            PH_SIZE: chk_add = asm_or;
            default: chk_add = 32'd2;
        endcase
    end

    assign sum_chk = {1'b0, next_off} + {2'b00, chk_add};

    always_comb
    begin
        off_next   = e_off;
        phase_next = e_phase;
        rem_next   = e_rem;
        ftot_next  = e_ftot;
        cur_next   = e_cur;
        asm_next   = e_asm;
        mark_next  = e_mark;
        stat_next  = e_stat;
        role       = ROLE_IGNORED;
        absv       = e_mark;
        fend       = 1'b0;

        if (e_stat == ST_RUNNING)
        begin
            off_next = next_off[31:0];
            case (e_phase)
                PH_HEADER:
                begin
                    role = ROLE_HEADER;
                    case (e_off[2:0])
                        3'd0:
                        begin
                            asm_next = {24'b0, b};
                            if (pkg_len_reg < HEADER_BYTES)
                            begin
                                stat_next  = ST_TOO_SMALL;
                                phase_next = PH_STOP;
                            end
                        end
                        3'd1, 3'd2:
                        begin
                            asm_next = asm_or;
                        end
                        3'd3:
                        begin
                            asm_next = asm_or;
                            if (asm_or != MAGIC_WORD)
                            begin
                                stat_next  = ST_BAD_MAGIC;
                                phase_next = PH_STOP;
                            end
                        end
                        3'd4:
                        begin
                            if (b != FMT_VERSION)
                            begin
                                stat_next  = ST_BAD_VER;
                                phase_next = PH_STOP;
                            end
                        end
                        3'd5:
                        begin
                            asm_next = {24'b0, b};
                        end
                        default:
                        begin
                            asm_next  = asm_or;
                            ftot_next = asm_or[15:0];
                            if (asm_or[15:0] == 16'd0)
                            begin
                                stat_next  = ST_DONE;
                                phase_next = PH_STOP;
                            end
                            else if (sum_two > len_ext)
                            begin
                                stat_next  = ST_TRUNC_PLEN;
                                phase_next = PH_STOP;
                            end
                            else
                            begin
                                phase_next = PH_PLEN;
                                rem_next   = 32'd2;
                                asm_next   = '0;
                            end
                        end
                    endcase
                end
                PH_PLEN:
                begin
                    role     = ROLE_PLEN;
                    asm_next = asm_or;
                    rem_next = {30'b0, rem_dec[1:0]};
                    if (rem_dec[1:0] == 2'd0)
                    begin
                        if (plen == 16'd0 || {1'b0, plen} >= 17'(MAX_PATH_BYTES)
                            || sum_chk > len_ext)
                        begin
                            stat_next  = ST_BAD_PATH;
                            phase_next = PH_STOP;
                        end
                        else
                        begin
                            phase_next = PH_PATH;
                            rem_next   = {16'b0, plen};
                            asm_next   = {16'b0, plen};
                        end
                    end
                end
                PH_PATH:
                begin
                    role = ROLE_PATH;
                    if (e_rem == e_asm)
                    begin
                        mark_next = (b == SLASH_CHAR);
                        absv      = (b == SLASH_CHAR);
                    end
                    rem_next = rem_dec;
                    if (rem_dec == 32'd0)
                    begin
                        if (sum_chk > len_ext)
                        begin
                            stat_next  = ST_TRUNC_SIZE;
                            phase_next = PH_STOP;
                        end
                        else
                        begin
                            phase_next = PH_SIZE;
                            rem_next   = 32'd4;
                            asm_next   = '0;
                        end
                    end
                end
                PH_SIZE:
                begin
                    role     = ROLE_SIZE;
                    asm_next = asm_or;
                    rem_next = {29'b0, rem_dec[2:0]};
                    if (rem_dec[2:0] == 3'd0)
                    begin
                        if (sum_chk > len_ext)
                        begin
                            stat_next  = ST_TRUNC_DATA;
                            phase_next = PH_STOP;
                        end
                        else if (asm_or == 32'd0)
                        begin
                            fend      = 1'b1;
                            cur_next  = cur_inc;
                            mark_next = 1'b0;
                            if (cur_inc == e_ftot)
                            begin
                                stat_next  = ST_DONE;
                                phase_next = PH_STOP;
                            end
                            else if (sum_two > len_ext)
                            begin
                                stat_next  = ST_TRUNC_PLEN;
                                phase_next = PH_STOP;
                            end
                            else
                            begin
                                phase_next = PH_PLEN;
                                rem_next   = 32'd2;
                                asm_next   = '0;
                            end
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                            rem_next   = asm_or;
                        end
                    end
                end
                PH_DATA:
                begin
                    role     = e_mark ? ROLE_DATA : ROLE_SKIPPED;
                    rem_next = rem_dec;
                    if (rem_dec == 32'd0)
                    begin
                        fend      = 1'b1;
                        cur_next  = cur_inc;
                        mark_next = 1'b0;
                        if (cur_inc == e_ftot)
                        begin
                            stat_next  = ST_DONE;
                            phase_next = PH_STOP;
                        end
                        else if (sum_two > len_ext)
                        begin
                            stat_next  = ST_TRUNC_PLEN;
                            phase_next = PH_STOP;
                        end
                        else
                        begin
                            phase_next = PH_PLEN;
                            rem_next   = 32'd2;
                            asm_next   = '0;
                        end
                    end
                end
                default:
                begin
                    role = ROLE_IGNORED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkg_len_reg <= '0;
        end
        else if (cfg_we)
        begin
            pkg_len_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_start_reg <= item.start_flag;
            s1_byte_reg  <= item.data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg   <= '0;
            phase_reg <= PH_HEADER;
            rem_reg   <= '0;
            ftot_reg  <= '0;
            cur_reg   <= '0;
            asm_reg   <= '0;
            mark_reg  <= 1'b0;
            stat_reg  <= ST_RUNNING;
        end
        else if (fire)
        begin
            off_reg   <= off_next;
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            ftot_reg  <= ftot_next;
            cur_reg   <= cur_next;
            asm_reg   <= asm_next;
            mark_reg  <= mark_next;
            stat_reg  <= stat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_byte_reg   <= b;
            out_role_reg   <= role;
            out_index_reg  <= e_cur;
            out_abs_reg    <= absv;
            out_fend_reg   <= fend;
            out_status_reg <= stat_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.byte_out      = out_byte_reg;
    assign result.byte_role     = out_role_reg;
    assign result.file_index    = out_index_reg;
    assign result.path_absolute = out_abs_reg;
    assign result.file_end      = out_fend_reg;
    assign result.parse_status  = out_status_reg;

endmodule

@@ test/package_archive_deframer_test.sv @@
// Testbench for the package archive deframer: directed and random archives, scoreboard check.
module package_archive_deframer_test
    import pad_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PERIOD       = 10;
    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned RANDOM_BYTES = 1650;
    localparam int unsigned HOLD_CYCLES  = 120;
    localparam int unsigned STALL_LIMIT  = 3000;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] data;
    } feed_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        role_t              role;
        logic [INDEX_W-1:0] index;
        logic               absolute;
        logic               last;
        status_t            status;
    } tag_t;

    typedef enum logic {ROW_BYTE, ROW_LENGTH} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        feed_t       feed;
        logic [31:0] length;
        bit          fixed;
        tag_t        want;
    } stim_row_t;

    typedef enum int unsigned {
        FLT_MAGIC, FLT_VERSION, FLT_PATH_LEN, FLT_TRUNCATE, FLT_TOO_SMALL,
        FLT_ROOMY, FLT_RESTART, FLT_EXTRA_FILES, FLT_CLEAN
    } fault_t;

    typedef enum int unsigned {RX_OPEN, RX_SPOTTY, RX_PERIODIC, RX_CHOKED} rx_mode_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_wdata;

    pad_in_if  arc_in ();
    pad_out_if tag_out ();

    package_archive_deframer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (arc_in),
        .result    (tag_out)
    );

    always #(PERIOD / 2) clk = ~clk;

    // parser image
    logic [31:0] arc_len;
    logic [31:0] arc_offset;
    phase_t      arc_phase;
    logic [31:0] arc_remaining;
    logic [15:0] arc_total;
    logic [15:0] arc_file;
    logic [31:0] arc_word;
    logic        arc_abs;
    status_t     arc_status;

    tag_t        expected_tags[$];
    stim_row_t   directed_rows[$];
    feed_t       archive_bytes[$];
    int unsigned mismatches   = 0;
    int unsigned sent_bytes   = 0;
    int unsigned burst_left   = 0;
    bit          quiet_mode   = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned idle_cycles  = 0;

    function automatic void clear_parser();
        arc_offset    = '0;
        arc_phase     = PH_HEADER;
        arc_remaining = '0;
        arc_total     = '0;
        arc_file      = '0;
        arc_word      = '0;
        arc_abs       = 1'b0;
        arc_status    = ST_RUNNING;
    endfunction

    function automatic void halt_parse(status_t code);
        arc_status = code;
        arc_phase  = PH_STOP;
    endfunction

    function automatic void open_path_length(longint unsigned nxt);
        if (nxt + 2 > arc_len)
        begin
            halt_parse(ST_TRUNC_PLEN);
        end
        else
        begin
            arc_phase     = PH_PLEN;
            arc_remaining = 32'd2;
            arc_word      = '0;
        end
    endfunction

    function automatic void close_entry(longint unsigned nxt);
        arc_file = arc_file + 16'd1;
        arc_abs  = 1'b0;
        if (arc_file == arc_total)
            halt_parse(ST_DONE);
        else
            open_path_length(nxt);
    endfunction

    function automatic tag_t tag_byte(logic start, logic [7:0] b);
        tag_t            t;
        longint unsigned nxt;
        logic [15:0]     plen;
        int unsigned     shift;
        if (start)
            clear_parser();
        t.data     = b;
        t.role     = ROLE_IGNORED;
        t.index    = arc_file;
        t.absolute = arc_abs;
        t.last     = 1'b0;
        nxt = {32'd0, arc_offset} + 64'd1;
        if (arc_status == ST_RUNNING)
        begin
            case (arc_phase)
                PH_HEADER:
                begin
                    t.role = ROLE_HEADER;
                    if (arc_offset == 0)
                    begin
                        arc_word = 32'(b);
                        if (arc_len < HEADER_BYTES)
                            halt_parse(ST_TOO_SMALL);
                    end
                    else if (arc_offset < 4)
                    begin
                        arc_word = arc_word | (32'(b) << (8 * arc_offset));
                        if (arc_offset == 3 && arc_word != MAGIC_WORD)
                            halt_parse(ST_BAD_MAGIC);
                    end
                    else if (arc_offset == 4)
                    begin
                        if (b != FMT_VERSION)
                            halt_parse(ST_BAD_VER);
                    end
                    else if (arc_offset == 5)
                    begin
                        arc_word = 32'(b);
                    end
                    else
                    begin
                        arc_word  = arc_word | (32'(b) << 8);
                        arc_total = arc_word[15:0];
                        if (arc_total == 0)
                            halt_parse(ST_DONE);
                        else
                            open_path_length(nxt);
                    end
                end
                PH_PLEN:
                begin
                    t.role = ROLE_PLEN;
                    arc_word = arc_word |
                               ((arc_remaining == 2) ? 32'(b) : (32'(b) << 8));
                    arc_remaining = (arc_remaining - 1) & 32'd3;
                    if (arc_remaining == 0)
                    begin
                        plen = arc_word[15:0];
                        if (plen == 0 || plen >= MAX_PATH_BYTES || nxt + plen > arc_len)
                        begin
                            halt_parse(ST_BAD_PATH);
                        end
                        else
                        begin
                            arc_phase     = PH_PATH;
                            arc_remaining = 32'(plen);
                            arc_word      = 32'(plen);
                        end
                    end
                end
                PH_PATH:
                begin
                    t.role = ROLE_PATH;
                    if (arc_remaining == arc_word)
                        arc_abs = (b == SLASH_CHAR);
                    t.absolute = arc_abs;
                    arc_remaining = arc_remaining - 1;
                    if (arc_remaining == 0)
                    begin
                        if (nxt + 4 > arc_len)
                        begin
                            halt_parse(ST_TRUNC_SIZE);
                        end
                        else
                        begin
                            arc_phase     = PH_SIZE;
                            arc_remaining = 32'd4;
                            arc_word      = '0;
                        end
                    end
                end
                PH_SIZE:
                begin
                    t.role = ROLE_SIZE;
                    shift = (4 - (arc_remaining & 3)) & 3;
                    arc_word = arc_word | (32'(b) << (8 * shift));
                    arc_remaining = (arc_remaining - 1) & 32'd7;
                    if (arc_remaining == 0)
                    begin
                        if (nxt + arc_word > arc_len)
                        begin
                            halt_parse(ST_TRUNC_DATA);
                        end
                        else if (arc_word == 0)
                        begin
                            t.last = 1'b1;
                            close_entry(nxt);
                        end
                        else
                        begin
                            arc_phase     = PH_DATA;
                            arc_remaining = arc_word;
                        end
                    end
                end
                PH_DATA:
                begin
                    t.role = arc_abs ? ROLE_DATA : ROLE_SKIPPED;
                    arc_remaining = arc_remaining - 1;
                    if (arc_remaining == 0)
                    begin
                        t.last = 1'b1;
                        close_entry(nxt);
                    end
                end
                default:
                begin
                    t.role = ROLE_IGNORED;
                end
            endcase
            arc_offset = nxt[31:0];
        end
        t.status = arc_status;
        return t;
    endfunction

    function automatic void row_byte(logic start, logic [7:0] b);
        stim_row_t r;
        r.kind       = ROW_BYTE;
        r.feed.start = start;
        r.feed.data  = b;
        r.length     = '0;
        r.fixed      = 1'b0;
        r.want       = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void row_check(logic start, logic [7:0] b, role_t role,
                                      logic [15:0] idx, logic abs_mark, logic last,
                                      status_t status);
        int unsigned n;
        row_byte(start, b);
        n = directed_rows.size() - 1;
        directed_rows[n].fixed = 1'b1;
        directed_rows[n].want  = '{b, role, idx, abs_mark, last, status};
    endfunction

    function automatic void row_length(logic [31:0] value);
        stim_row_t r;
        r.kind   = ROW_LENGTH;
        r.feed   = '0;
        r.length = value;
        r.fixed  = 1'b0;
        r.want   = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void row_magic();
        for (int k = 0; k < 4; k++)
            row_byte(k == 0, MAGIC_WORD[8 * k +: 8]);
    endfunction

    function automatic void put_le(logic [31:0] value, int unsigned count);
        for (int k = 0; k < count; k++)
            archive_bytes.push_back('{1'b0, value[8 * k +: 8]});
    endfunction

    function automatic void build_archive(int unsigned files, int unsigned declared);
        int unsigned plen;
        int unsigned fsize;
        archive_bytes.delete();
        put_le(MAGIC_WORD, 4);
        archive_bytes[0].start = 1'b1;
        put_le(32'(FMT_VERSION), 1);
        put_le(declared, 2);
        for (int f = 0; f < files; f++)
        begin
            plen = ($urandom_range(0, 15) == 0) ? MAX_PATH_BYTES - 1
                                                : $urandom_range(1, 6);
            put_le(plen, 2);
            for (int k = 0; k < plen; k++)
                put_le((k == 0 && $urandom_range(0, 1) == 1) ? 32'(SLASH_CHAR)
                                                            : $urandom_range(0, 255), 1);
            case ($urandom_range(0, 19))
                0, 1, 2, 3: fsize = 0;
                4:          fsize = $urandom_range(30, 80);
                default:    fsize = $urandom_range(1, 10);
            endcase
            put_le(fsize, 4);
            repeat (fsize) put_le($urandom_range(0, 255), 1);
        end
    endfunction

    function automatic void note_failure(string what, tag_t want, tag_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display({"%0t %s: exp data=%h role=%0d idx=%0d abs=%0d end=%0d st=%0d",
                      " | got data=%h role=%0d idx=%0d abs=%0d end=%0d st=%0d"},
                     $realtime, what, want.data, want.role, want.index, want.absolute,
                     want.last, want.status, got.data, got.role, got.index, got.absolute,
                     got.last, got.status);
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        arc_in.valid <= 1'b0;
        while (expected_tags.size() != 0) @(posedge clk);
    endtask

    task automatic write_length(logic [31:0] value);
        wait_drained();
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        arc_len = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_byte(feed_t f, bit fixed, tag_t want);
        tag_t        predicted;
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (quiet_mode)
                gap = 0;
            else if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 12);
            else
                gap = $urandom_range(0, 2);
            if (gap != 0)
            begin
                @(negedge clk);
                arc_in.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        arc_in.valid      <= 1'b1;
        arc_in.start_flag <= f.start;
        arc_in.data_byte  <= f.data;
        @(posedge clk);
        while (arc_in.ready !== 1'b1) @(posedge clk);
        predicted = tag_byte(f.start, f.data);
        sent_bytes++;
        expected_tags.push_back(fixed ? want : predicted);
    endtask

    task automatic run_phase(int unsigned phase_no);
        feed_t       prefix[$];
        int unsigned files;
        int unsigned declared;
        int unsigned len;
        int unsigned pick;
        int unsigned cut;
        int unsigned pause_at;
        fault_t      fault;
        logic [15:0] bad_plen;
        logic [31:0] limit;
        files = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 4);
        pick  = $urandom_range(0, 17);
        fault = (pick < FLT_CLEAN) ? fault_t'(pick) : FLT_CLEAN;
        declared = files;
        if (fault == FLT_EXTRA_FILES)
            declared = ($urandom_range(0, 3) == 0) ? 16'hFFFF : files + $urandom_range(1, 3);
        build_archive(files, declared);
        len   = archive_bytes.size();
        limit = len;
        case (fault)
            FLT_MAGIC:
                archive_bytes[$urandom_range(0, 3)].data ^= 8'($urandom_range(1, 255));
            FLT_VERSION:
                archive_bytes[4].data ^= 8'($urandom_range(1, 255));
            FLT_PATH_LEN:
            begin
                case ($urandom_range(0, 3))
                    0:       bad_plen = 16'd0;
                    1:       bad_plen = 16'(MAX_PATH_BYTES);
                    2:       bad_plen = 16'hFFFF;
                    default: bad_plen = 16'($urandom_range(MAX_PATH_BYTES, 16'hFFFF));
                endcase
                if (files != 0)
                begin
                    archive_bytes[7].data = bad_plen[7:0];
                    archive_bytes[8].data = bad_plen[15:8];
                end
            end
            FLT_TRUNCATE:
                limit = $urandom_range(0, len - 1);
            FLT_TOO_SMALL:
                limit = $urandom_range(0, HEADER_BYTES - 1);
            FLT_ROOMY:
                limit = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF
                                                    : len + $urandom_range(1, 100);
            FLT_RESTART:
            begin
                cut = $urandom_range(1, len - 1);
                for (int k = 0; k < cut; k++)
                    prefix.push_back(archive_bytes[k]);
                for (int k = cut; k > 0; k--)
                    archive_bytes.push_front(prefix[k - 1]);
            end
            default: ;
        endcase
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 6))
                archive_bytes.push_back('{($urandom_range(0, 15) == 0),
                                          8'($urandom_range(0, 255))});
        write_length(limit);
        quiet_mode = ($urandom_range(0, 3) == 0);
        if (phase_no % 13 == 4)
            hold_request = 1'b1;
        pause_at = (phase_no % 7 == 2) ? $urandom_range(1, archive_bytes.size() - 1) : 0;
        foreach (archive_bytes[k])
        begin
            if (pause_at != 0 && k == pause_at)
                wait_drained();
            send_byte(archive_bytes[k], 1'b0, '0);
        end
    endtask

    initial
    begin : stimulus
        int unsigned phase_no;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        arc_in.valid      = 1'b0;
        arc_in.start_flag = 1'b0;
        arc_in.data_byte  = '0;
        arc_len           = '0;
        clear_parser();

        row_check(1'b0, 8'hFF, ROLE_HEADER, 16'd0, 1'b0, 1'b0, ST_TOO_SMALL);
        row_check(1'b0, 8'h00, ROLE_IGNORED, 16'd0, 1'b0, 1'b0, ST_TOO_SMALL);
        row_length(32'hFFFF_FFFF);
        row_byte(1'b1, MAGIC_WORD[7:0]);
        row_byte(1'b0, MAGIC_WORD[15:8]);
        row_byte(1'b0, MAGIC_WORD[23:16]);
        row_check(1'b0, 8'h00, ROLE_HEADER, 16'd0, 1'b0, 1'b0, ST_BAD_MAGIC);
        row_magic();
        row_check(1'b0, 8'hFE, ROLE_HEADER, 16'd0, 1'b0, 1'b0, ST_BAD_VER);
        row_magic();
        row_byte(1'b0, FMT_VERSION);
        row_byte(1'b0, 8'h00);
        row_check(1'b0, 8'h00, ROLE_HEADER, 16'd0, 1'b0, 1'b0, ST_DONE);
        // one absolute entry with an empty body
        row_length(32'd14);
        row_magic();
        row_byte(1'b0, FMT_VERSION);
        row_byte(1'b0, 8'h01);
        row_byte(1'b0, 8'h00);
        row_byte(1'b0, 8'h01);
        row_byte(1'b0, 8'h00);
        row_check(1'b0, SLASH_CHAR, ROLE_PATH, 16'd0, 1'b1, 1'b0, ST_RUNNING);
        row_byte(1'b0, 8'h00);
        row_byte(1'b0, 8'h00);
        row_byte(1'b0, 8'h00);
        row_check(1'b0, 8'h00, ROLE_SIZE, 16'd0, 1'b1, 1'b1, ST_DONE);
        row_check(1'b0, 8'hA5, ROLE_IGNORED, 16'd1, 1'b0, 1'b0, ST_DONE);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_LENGTH)
                write_length(directed_rows[r].length);
            else
                send_byte(directed_rows[r].feed, directed_rows[r].fixed, directed_rows[r].want);
        end

        sent_bytes = 0;
        phase_no   = 0;
        while (sent_bytes < RANDOM_BYTES)
        begin
            run_phase(phase_no);
            phase_no++;
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_tags.size() == 0)
            $display("package_archive_deframer_test OK");
        else
            $display("package_archive_deframer_test NOT OK");
        $finish;
    end

    initial
    begin : receiver
        rx_mode_t    mode;
        int unsigned cyc;
        mode          = RX_OPEN;
        cyc           = 0;
        tag_out.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                tag_out.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                if (cyc % 96 == 0)
                    mode = rx_mode_t'($urandom_range(0, 3));
                cyc++;
                case (mode)
                    RX_OPEN:     tag_out.ready <= 1'b1;
                    RX_SPOTTY:   tag_out.ready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: tag_out.ready <= ((cyc % 8) < 5);
                    default:     tag_out.ready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : scoreboard
        tag_t got;
        tag_t want;
        if (rst_n === 1'b1 && tag_out.valid === 1'b1 && tag_out.ready === 1'b1)
        begin
            got = '{tag_out.byte_out, tag_out.byte_role, tag_out.file_index,
                    tag_out.path_absolute, tag_out.file_end, tag_out.parse_status};
            if (expected_tags.size() == 0)
            begin
                note_failure("transfer with nothing expected", '0, got);
            end
            else
            begin
                want = expected_tags.pop_front();
                if (got.data !== want.data || got.role !== want.role ||
                    got.index !== want.index || got.absolute !== want.absolute ||
                    got.last !== want.last || got.status !== want.status)
                    note_failure("mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((arc_in.valid === 1'b1 && arc_in.ready === 1'b1) ||
            (tag_out.valid === 1'b1 && tag_out.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("package_archive_deframer_test NOT OK");
            $finish;
        end
    end

endmodule
